@@ sv/utf8_segment_han_classify_top_assert.svh @@
// ----------------------------------------------------------------------------
// utf8 segmenter assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef UTF8_SEGMENT_HAN_CLASSIFY_TOP_ASSERT_SVH
`define UTF8_SEGMENT_HAN_CLASSIFY_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define U8HAN_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("u8han check failed");

// next-cycle implication, disabled during reset
`define U8HAN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("u8han check failed");

`endif

@@ sv/u8han_pkg.sv @@
// ----------------------------------------------------------------------------
// u8han_pkg
// types, constants and helper functions of the utf8 segmenter
// ----------------------------------------------------------------------------
package u8han_pkg;

  localparam int unsigned BufDepth = 4;

  typedef logic [BufDepth-1:0][7:0] buf_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // take a new byte into the buffer
    logic step;   // emit one character and shift it out
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hold;      // nothing can be emitted at the current position
    logic last;      // the character about to be emitted ends the run
    logic out_free;  // output register can take a new character
  } status_t;

  localparam logic [20:0] HanZero    = 21'h003007;
  localparam logic [20:0] HanExtALo  = 21'h003400;
  localparam logic [20:0] HanExtAHi  = 21'h004DBF;
  localparam logic [20:0] HanUniLo   = 21'h004E00;
  localparam logic [20:0] HanUniHi   = 21'h009FFF;
  localparam logic [20:0] HanCompLo  = 21'h00F900;
  localparam logic [20:0] HanCompHi  = 21'h00FAFF;
  localparam logic [20:0] HanExtBLo  = 21'h020000;
  localparam logic [20:0] HanExtBHi  = 21'h02A6DF;
  localparam logic [20:0] HanExtCLo  = 21'h02A700;
  localparam logic [20:0] HanExtCHi  = 21'h02EBEF;
  localparam logic [20:0] HanExtGLo  = 21'h030000;
  localparam logic [20:0] HanExtGHi  = 21'h0323AF;

  // sequence length announced by a lead byte, bad leads count as one
  function automatic logic [2:0] lead_len(input logic [7:0] c);
    logic [2:0] len;
    if (c[7] == 1'b0) begin
      len = 3'd1;
    end else if (c[7:5] == 3'b110) begin
      len = 3'd2;
    end else if (c[7:4] == 4'b1110) begin
      len = 3'd3;
    end else if (c[7:3] == 5'b11110) begin
      len = 3'd4;
    end else begin
      len = 3'd1;
    end
    return len;
  endfunction

  // all present bytes after the lead, up to len, are continuations
  function automatic logic cont_ok(input buf_t b, input logic [2:0] n,
                                   input logic [2:0] len);
    logic ok;
    ok = 1'b1;
    for (int i = 1; i < BufDepth; i++) begin
      if ((3'(i) < len) && (3'(i) < n) && (b[i][7:6] != 2'b10)) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  // a valid multi-byte prefix that still waits for more bytes
  function automatic logic pending(input buf_t b, input logic [2:0] n);
    logic [2:0] len;
    len = lead_len(b[0]);
    return (len != 3'd1) && cont_ok(b, n, len) && (n < len);
  endfunction

  function automatic logic han_flag(input logic [20:0] cp, input logic [2:0] len);
    logic h;
    h = 1'b0;
    if (len == 3'd3) begin
      h = (cp == HanZero) ||
          ((cp >= HanExtALo) && (cp <= HanExtAHi)) ||
          ((cp >= HanUniLo) && (cp <= HanUniHi)) ||
          ((cp >= HanCompLo) && (cp <= HanCompHi));
    end else if (len == 3'd4) begin
      h = ((cp >= HanExtBLo) && (cp <= HanExtBHi)) ||
          ((cp >= HanExtCLo) && (cp <= HanExtCHi)) ||
          ((cp >= HanExtGLo) && (cp <= HanExtGHi));
    end
    return h;
  endfunction

endpackage

@@ sv/u8han_ctrl.sv @@
// ----------------------------------------------------------------------------
// u8han_ctrl
// sequencing controller: load one byte, then emit characters until done
// ----------------------------------------------------------------------------
module u8han_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  u8han_pkg::status_t st,
  output u8han_pkg::cmd_t    cmd
);
  import u8han_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_WORK
  } state_t;

  state_t state_r, state_nxt;
  logic   in_tready_r;

  assign in_tready = in_tready_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid && in_tready_r) begin
          cmd.load  = 1'b1;
          state_nxt = ST_WORK;
        end
      end
      ST_WORK: begin
        if (st.hold) begin
          state_nxt = ST_IDLE;
        end else if (st.out_free) begin
          cmd.step = 1'b1;
          if (st.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_tready_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_tready_r <= (state_nxt == ST_IDLE);
    end
  end

endmodule

@@ sv/u8han_datapath.sv @@
// ----------------------------------------------------------------------------
// u8han_datapath
// byte buffer, character decode, han test and output register
// ----------------------------------------------------------------------------
module u8han_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  u8han_pkg::cmd_t    cmd,
  output u8han_pkg::status_t st,
  input  logic [7:0]         in_byte,
  input  logic               in_end,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [20:0]        out_value,
  output logic [2:0]         out_len,
  output logic               out_han,
  output logic               out_last
);
  import u8han_pkg::*;

  buf_t        buf_r, buf_nxt;
  logic [2:0]  n_r, n_nxt;
  logic        end_r;
  logic        out_tvalid_r;
  logic [20:0] out_value_r;
  logic [2:0]  out_len_r;
  logic        out_han_r;
  logic        out_last_r;

  logic [2:0]  len;
  logic        full_ok;
  logic [2:0]  k;
  logic [20:0] cp;
  buf_t        buf_sh;
  logic [2:0]  n_sh;
  logic [2:0]  idx;

  assign len     = lead_len(buf_r[0]);
  assign full_ok = (len != 3'd1) && cont_ok(buf_r, n_r, len) && (n_r >= len);
  assign k       = full_ok ? len : 3'd1;

  always_comb begin
    case (k)
      3'd2:    cp = {10'd0, buf_r[0][4:0], buf_r[1][5:0]};
      3'd3:    cp = {5'd0, buf_r[0][3:0], buf_r[1][5:0], buf_r[2][5:0]};
      3'd4:    cp = {buf_r[0][2:0], buf_r[1][5:0], buf_r[2][5:0], buf_r[3][5:0]};
      default: cp = {13'd0, buf_r[0]};
    endcase
  end

  // buffer after the emitted character is shifted out
  always_comb begin
    buf_sh = buf_r;
    idx    = '0;
    for (int i = 0; i < BufDepth; i++) begin
      idx = 3'(i) + k;
      if (idx < 3'(BufDepth)) begin
        buf_sh[i] = buf_r[idx[1:0]];
      end
    end
  end

  assign n_sh = n_r - k;

  assign st.hold     = (n_r == 3'd0) || (!end_r && pending(buf_r, n_r));
  assign st.last     = (n_sh == 3'd0) || (!end_r && pending(buf_sh, n_sh));
  assign st.out_free = !out_tvalid_r || out_tready;

  always_comb begin
    buf_nxt = buf_r;
    n_nxt   = n_r;
    if (cmd.load) begin
      buf_nxt[n_r[1:0]] = in_byte;
      n_nxt             = n_r + 3'd1;
    end else if (cmd.step) begin
      buf_nxt = buf_sh;
      n_nxt   = n_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r          <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      n_r <= n_nxt;
      if (cmd.step) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    if (cmd.load) begin
      end_r <= in_end;
    end
    if (cmd.step) begin
      out_value_r <= cp;
      out_len_r   <= k;
      out_han_r   <= han_flag(cp, k);
      out_last_r  <= st.last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_value  = out_value_r;
  assign out_len    = out_len_r;
  assign out_han    = out_han_r;
  assign out_last   = out_last_r;

endmodule

@@ sv/utf8_segment_han_classify_top.sv @@
// ----------------------------------------------------------------------------
// utf8_segment_han_classify_top
// utf8 character segmenter with han ideograph flag
// ----------------------------------------------------------------------------
//  channel | dir | tdata                          | tlast        | tuser
//  in_     | in  | data_byte[7:0]                 | line_end     | -
//  out_    | out | char_value, char_length, is_han| last_of_run  | -
//
//  a byte transfer is loaded into the byte buffer, then the characters at
//  the buffer head are emitted (up to four) through the single output
//  register; a byte that only extends a held sequence emits nothing
//  rst_n is synchronous and clears the held byte count, the sequencer state
//  and the output valid; in_tready is low in reset and the first cycle after
//  a stalled output holds the decoder; a byte may be taken while the last
//  character of the previous byte still waits in the output register
module utf8_segment_han_classify_top (
  input  logic        clk,
  input  logic        rst_n,
  // input byte stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // line_end
  // character stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [20:0] char_value, [23:21] char_length,
                                  // [24] is_han, [31:25] zero
  output logic        out_tlast   // last_of_run
);
  import u8han_pkg::*;

  cmd_t        cmd;
  status_t     st;
  logic [20:0] out_value;
  logic [2:0]  out_len;
  logic        out_han;

  // sequencer: idle waits for a byte, work emits one character per cycle while the output register is free
  u8han_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  // held bytes plus the new one, decode at the buffer head, output register
  u8han_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_byte    (in_tdata),
    .in_end     (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_value  (out_value),
    .out_len    (out_len),
    .out_han    (out_han),
    .out_last   (out_tlast)
  );

  // pack the character fields, lowest field first
  assign out_tdata = {7'd0, out_han, out_len, out_value};

endmodule

@@ sv/u8han_checker.sv @@
// ----------------------------------------------------------------------------
// u8han_checker
// port-level checks of the utf8 segmenter
// ----------------------------------------------------------------------------
`include "utf8_segment_han_classify_top_assert.svh"

module u8han_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // stalled character stays offered
  `U8HAN_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)

  // a byte transfer is always followed by a busy cycle
  `U8HAN_ASSERT_NEXT(a_busy_after_in, in_tvalid && in_tready, !in_tready)

  // character length is one to four
  `U8HAN_ASSERT_IMPL(a_len_range, out_tvalid,
                     out_tdata[23:21] == 3'd1 || out_tdata[23:21] == 3'd2 ||
                     out_tdata[23:21] == 3'd3 || out_tdata[23:21] == 3'd4)

  // han only for three- and four-byte characters
  `U8HAN_ASSERT_IMPL(a_han_len, out_tvalid && out_tdata[24],
                     out_tdata[23:21] == 3'd3 || out_tdata[23:21] == 3'd4)

  // one-byte characters carry a raw byte
  `U8HAN_ASSERT_IMPL(a_one_byte_value, out_tvalid && out_tdata[23:21] == 3'd1,
                     out_tdata[20:8] == 13'd0)

endmodule

bind utf8_segment_han_classify_top u8han_checker u_u8han_checker (.*);
